FILE: rtl/core/swm_pkg.sv
// Shared types for the substring window matcher: transfer payloads,
// operation codes and the control bundle that drives the cell chain.
// No dependencies.
package swm_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_in;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_position;
        logic [6:0]  pattern_length;
        logic        overflow;
    } rsp_t;

    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/swm_cell.sv
// One cell of the matcher chain: holds one pattern byte (newest first),
// its occupancy bit and one text window byte; compares the pattern byte with the incoming window byte.
// Depends on swm_pkg.
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] pat_prev,
    input  logic       act_prev,
    input  logic [7:0] txt_prev,
    output logic [7:0] pat,
    output logic       act,
    output logic [7:0] txt,
    output logic       hit
);

    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       act_reg;
    logic       act_next;
    logic [7:0] txt_reg;
    logic [7:0] txt_next;

    always_comb
    begin
        pat_next = ctrl.pat_shift ? pat_prev : pat_reg;
        act_next = act_reg;
        txt_next = txt_reg;
        if (ctrl.clear)
        begin
            act_next = 1'b0;
            txt_next = 8'd0;
        end
        else
        begin
            if (ctrl.pat_shift)
            begin
                act_next = act_prev;
            end
            if (ctrl.txt_shift)
            begin
                txt_next = txt_prev;
            end
        end
    end

    // compare against the window byte this cell holds after the shift
    assign hit = !act_reg || (pat_reg == txt_prev);

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            txt_reg <= 8'd0;
        end
        else
        begin
            act_reg <= act_next;
            txt_reg <= txt_next;
        end
    end

    assign pat = pat_reg;
    assign act = act_reg;
    assign txt = txt_reg;

endmodule

FILE: rtl/core/substring_window_matcher.sv
// Substring window matcher: one transfer per cycle unless a response waits
// on rsp_ready; result registered, valid in the cycle after the transfer.
// The chain of MAX_PATTERN cells compares every byte pair at once.
// Reset (asynchronous, active low) empties the pattern and window and
// clears position, match and overflow state. Depends on swm_pkg, swm_cell.
module substring_window_matcher
    import swm_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int POS_BITS    = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic                accept;
    cell_ctrl_t          ctrl;
    logic [7:0]          pat_chain [MAX_PATTERN + 1];
    logic                act_chain [MAX_PATTERN + 1];
    logic [7:0]          txt_chain [MAX_PATTERN + 1];
    logic [MAX_PATTERN-1:0] hit;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic                found_reg;
    logic                found_next;
    logic [POS_BITS-1:0] first_reg;
    logic [POS_BITS-1:0] first_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic                full;
    logic                sat;
    logic [POS_BITS:0]   pos_inc;
    logic                enough;
    logic                match;
    logic [POS_BITS+15:0] first_ext;
    logic [CNT_W+6:0]    count_ext;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign full    = (count_reg == CNT_W'(MAX_PATTERN));
    assign sat     = (pos_reg == {POS_BITS{1'b1}});
    assign pos_inc = {1'b0, pos_reg} + {{POS_BITS{1'b0}}, 1'b1};
    assign enough  = (pos_inc >= (POS_BITS + 1)'(count_reg));

    always_comb
    begin
        ctrl.pat_shift = accept && (req.op == OP_APPEND) && !full;
        ctrl.txt_shift = accept && (req.op == OP_TEXT);
        ctrl.clear     = accept && (req.op == OP_CLEAR);
    end

    assign pat_chain[0] = req.char_in;
    assign act_chain[0] = 1'b1;
    assign txt_chain[0] = req.char_in;

    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        swm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pat_prev (pat_chain[g]),
            .act_prev (act_chain[g]),
            .txt_prev (txt_chain[g]),
            .pat      (pat_chain[g + 1]),
            .act      (act_chain[g + 1]),
            .txt      (txt_chain[g + 1]),
            .hit      (hit[g])
        );
    end

    assign match = !sat && !found_reg && (count_reg != '0) && enough && (&hit);

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            unique case (req.op)
                OP_APPEND:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_TEXT:
                begin
                    if (!sat)
                    begin
                        pos_next = pos_inc[POS_BITS-1:0];
                    end
                    if (match)
                    begin
                        found_next = 1'b1;
                        first_next = pos_inc[POS_BITS-1:0] - POS_BITS'(count_reg);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    first_next = '0;
                    ovf_next   = 1'b0;
                end
                OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign first_ext = {16'd0, first_next};
    assign count_ext = {7'd0, count_next};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.found          = found_next;
            rsp_next.match_position = found_next ? first_ext[15:0] : 16'd0;
            rsp_next.pattern_length = count_ext[6:0];
            rsp_next.overflow       = ovf_next;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            first_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
